// ===== design/sparse_column_matrix_store_unit_assert.svh =====
// assertion macros for the sparse column matrix store
`ifndef SPARSE_COLUMN_MATRIX_STORE_UNIT_ASSERT_SVH
`define SPARSE_COLUMN_MATRIX_STORE_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SCMSU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check, also active during reset
`define SCMSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/scmsu_pkg.sv =====
// shared types, codes and helpers of the sparse column matrix store
package scmsu_pkg;

   localparam int ROW_W           = 6;
   localparam int COL_W           = 6;
   localparam int VAL_W           = 64;
   localparam int SIZE_W          = 7;
   localparam int DEF_MAX_DIM     = 64;
   localparam int DEF_MAX_ENTRIES = 1024;
   localparam int REQ_W           = 80;
   localparam int RSP_W           = 72;

   typedef enum logic [1:0] {
      CMD_GET   = 2'd0,
      CMD_SET   = 2'd1,
      CMD_ADD   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic take_item;
      logic clr_start;
      logic clr_step;
      logic rd_start;
      logic rd_end;
      logic latch_start;
      logic latch_end;
      logic ptr_inc;
      logic ptr_dec;
      logic get_hit;
      logic hit_write;
      logic shift_init;
      logic shift_wr;
      logic ins_write;
      logic set_oor;
      logic set_full;
      logic cs_wr;
      logic cptr_inc;
      logic rsp_load;
   } scmsu_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic csr_fire;
      logic req_valid;
      logic is_clear;
      logic is_get;
      logic oor;
      logic ptr_eq_end;
      logic row_hit;
      logic full;
      logic shift_empty;
      logic cptr_eq_max;
      logic rsp_free;
   } scmsu_sts_type;

   function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      logic [VAL_W-1:0] s;
      s = a + b;
      if ((a[VAL_W-1] == b[VAL_W-1]) && (s[VAL_W-1] != a[VAL_W-1])) begin
         s = a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end
      return s;
   endfunction

endpackage

// ===== design/scmsu_ram.sv =====
// generic single write port ram with registered read
module scmsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/scmsu_ctrl.sv =====
// sequencing state machine of the sparse column matrix store
module scmsu_ctrl
   import scmsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  scmsu_sts_type sts,
   output scmsu_ctl_type ctl,
   output logic          req_ready
);
`include "sparse_column_matrix_store_unit_assert.svh"

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_DISP  = 13'b0000000000010,
      ST_CLEAR = 13'b0000000000100,
      ST_RDE   = 13'b0000000001000,
      ST_ENDW  = 13'b0000000010000,
      ST_SRCH  = 13'b0000000100000,
      ST_CMP   = 13'b0000001000000,
      ST_SHRD  = 13'b0000010000000,
      ST_SHWR  = 13'b0000100000000,
      ST_INS   = 13'b0001000000000,
      ST_CSRD  = 13'b0010000000000,
      ST_CSWR  = 13'b0100000000000,
      ST_RESP  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      clr_resp_ff, clr_resp_in;

   always_comb begin
      state_in    = state_ff;
      clr_resp_in = clr_resp_ff;
      ctl         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (sts.req_valid) begin
               ctl.take_item = 1'b1;
               state_in      = ST_DISP;
            end
         end
         ST_DISP: begin
            if (sts.is_clear) begin
               ctl.clr_start = 1'b1;
               clr_resp_in   = 1'b1;
               state_in      = ST_CLEAR;
            end else if (sts.oor) begin
               ctl.set_oor = 1'b1;
               state_in    = ST_RESP;
            end else begin
               ctl.rd_start = 1'b1;
               state_in     = ST_RDE;
            end
         end
         ST_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (sts.cptr_eq_max) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end else begin
               ctl.cptr_inc = 1'b1;
            end
         end
         ST_RDE: begin
            ctl.latch_start = 1'b1;
            ctl.rd_end      = 1'b1;
            state_in        = ST_ENDW;
         end
         ST_ENDW: begin
            ctl.latch_end = 1'b1;
            state_in      = ST_SRCH;
         end
         ST_SRCH: begin
            if (!sts.ptr_eq_end) begin
               state_in = ST_CMP;
            end else if (sts.is_get) begin
               state_in = ST_RESP;
            end else if (sts.full) begin
               ctl.set_full = 1'b1;
               state_in     = ST_RESP;
            end else if (sts.shift_empty) begin
               state_in = ST_INS;
            end else begin
               ctl.shift_init = 1'b1;
               state_in       = ST_SHRD;
            end
         end
         ST_CMP: begin
            if (sts.row_hit) begin
               if (sts.is_get) ctl.get_hit = 1'b1;
               else            ctl.hit_write = 1'b1;
               state_in = ST_RESP;
            end else begin
               ctl.ptr_inc = 1'b1;
               state_in    = ST_SRCH;
            end
         end
         ST_SHRD: begin
            state_in = ST_SHWR;
         end
         ST_SHWR: begin
            ctl.shift_wr = 1'b1;
            if (sts.ptr_eq_end) begin
               state_in = ST_INS;
            end else begin
               ctl.ptr_dec = 1'b1;
               state_in    = ST_SHRD;
            end
         end
         ST_INS: begin
            ctl.ins_write = 1'b1;
            state_in      = ST_CSRD;
         end
         ST_CSRD: begin
            state_in = ST_CSWR;
         end
         ST_CSWR: begin
            ctl.cs_wr = 1'b1;
            if (sts.cptr_eq_max) begin
               state_in = ST_RESP;
            end else begin
               ctl.cptr_inc = 1'b1;
               state_in     = ST_CSRD;
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a size write restarts the clearing pass from any state
      if (sts.csr_fire) begin
         ctl           = '0;
         req_ready     = 1'b0;
         ctl.clr_start = 1'b1;
         clr_resp_in   = 1'b0;
         state_in      = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_resp_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_resp_ff <= clr_resp_in;
      end
   end

   `SCMSU_ASSERT(a_take_leaves_idle, clock, reset, ctl.take_item |=> (state_ff != ST_IDLE), "accepted item did not start work")
   `SCMSU_ASSERT(a_rsp_into_free, clock, reset, ctl.rsp_load |-> sts.rsp_free, "result loaded over a waiting beat")
   `SCMSU_ASSERT(a_csr_clears, clock, reset, sts.csr_fire |=> (state_ff == ST_CLEAR), "size write did not start clearing")
   `SCMSU_ASSERT_ALWAYS(a_ready_idle, clock, req_ready |-> (state_ff == ST_IDLE), "ready outside idle")
endmodule

// ===== design/scmsu_dp.sv =====
// storage, pointers and result register of the sparse column matrix store
module scmsu_dp
   import scmsu_pkg::*;
#(
   parameter int MAX_DIM     = DEF_MAX_DIM,
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_wdata,
   input  logic              req_tvalid,
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,
   input  scmsu_ctl_type     ctl,
   output scmsu_sts_type     sts
);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int EA_W  = $clog2(MAX_ENTRIES);
   localparam int CA_W  = $clog2(MAX_DIM + 1);
   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int SW    = (DW > SIZE_W) ? DW : SIZE_W;
   localparam int EW    = ROW_W + VAL_W;

   logic [SIZE_W-1:0] size_ff;
   cmd_type           cmd_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [CNT_W-1:0]  count_ff, start_ff, end_ff, ptr_ff;
   logic [CA_W-1:0]   cptr_ff;
   logic [VAL_W-1:0]  res_val_ff;
   logic              res_pres_ff;
   status_type        res_stat_ff;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic [SW-1:0]     size_w, dim;
   logic              cs_we;
   logic [CA_W-1:0]   cs_raddr;
   logic [CNT_W-1:0]  cs_wdata, cs_rdata, end_clip;
   logic              ent_we;
   logic [EA_W-1:0]   ent_waddr;
   logic [EW-1:0]     ent_wdata, ent_rdata;
   logic [VAL_W-1:0]  new_val;

   assign csr_ready = 1'b1;

   assign size_w = SW'(size_ff);
   assign dim    = (size_w > SW'(MAX_DIM)) ? SW'(MAX_DIM) : size_w;

   // column start table
   assign cs_we    = ctl.clr_step | ctl.cs_wr;
   assign cs_wdata = ctl.clr_step ? '0 : cs_rdata + CNT_W'(1);
   always_comb begin
      priority if (ctl.rd_start) cs_raddr = CA_W'(col_ff);
      else if (ctl.rd_end)       cs_raddr = CA_W'(col_ff) + CA_W'(1);
      else                       cs_raddr = cptr_ff;
   end

   scmsu_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DIM + 1)) u_cs_ram (
      .clock (clock),
      .we    (cs_we),
      .waddr (cptr_ff),
      .wdata (cs_wdata),
      .raddr (cs_raddr),
      .rdata (cs_rdata)
   );

   // entry store: row index above value
   assign new_val = (cmd_ff == CMD_SET) ? val_ff : sat_add(ent_rdata[VAL_W-1:0], val_ff);
   assign ent_we  = ctl.hit_write | ctl.shift_wr | ctl.ins_write;
   always_comb begin
      priority if (ctl.hit_write) begin
         ent_waddr = ptr_ff[EA_W-1:0];
         ent_wdata = {row_ff, new_val};
      end else if (ctl.shift_wr) begin
         ent_waddr = EA_W'(ptr_ff + CNT_W'(1));
         ent_wdata = ent_rdata;
      end else begin
         ent_waddr = end_ff[EA_W-1:0];
         ent_wdata = {row_ff, val_ff};
      end
   end

   scmsu_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ent_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ptr_ff[EA_W-1:0]),
      .rdata (ent_rdata)
   );

   assign end_clip = (cs_rdata > count_ff) ? count_ff : cs_rdata;

   always_ff @(posedge clock) begin
      if (ctl.take_item) begin
         cmd_ff      <= cmd_type'(req_tdata[1:0]);
         row_ff      <= req_tdata[7:2];
         col_ff      <= req_tdata[13:8];
         val_ff      <= req_tdata[77:14];
         res_val_ff  <= '0;
         res_pres_ff <= 1'b0;
         res_stat_ff <= STATUS_OK;
      end
      if (ctl.latch_start) start_ff <= cs_rdata;
      if (ctl.latch_end) begin
         end_ff <= end_clip;
         ptr_ff <= start_ff;
      end
      if (ctl.ptr_inc)    ptr_ff <= ptr_ff + CNT_W'(1);
      if (ctl.ptr_dec)    ptr_ff <= ptr_ff - CNT_W'(1);
      if (ctl.shift_init) ptr_ff <= count_ff - CNT_W'(1);
      if (ctl.set_oor)    res_stat_ff <= STATUS_RANGE;
      if (ctl.set_full)   res_stat_ff <= STATUS_FULL;
      if (ctl.get_hit) begin
         res_val_ff  <= ent_rdata[VAL_W-1:0];
         res_pres_ff <= 1'b1;
      end
      if (ctl.hit_write) begin
         res_val_ff  <= new_val;
         res_pres_ff <= 1'b1;
      end
      if (ctl.ins_write) res_val_ff <= val_ff;
      if (ctl.rsp_load) rsp_data_ff <= {5'b0, res_stat_ff, res_pres_ff, res_val_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         count_ff     <= '0;
         cptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) size_ff <= csr_wdata;
         if (ctl.clr_start) begin
            count_ff <= '0;
            cptr_ff  <= '0;
         end
         if (ctl.cptr_inc) cptr_ff <= cptr_ff + CA_W'(1);
         if (ctl.ins_write) begin
            count_ff <= count_ff + CNT_W'(1);
            cptr_ff  <= CA_W'(col_ff) + CA_W'(1);
         end
         if (ctl.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      sts.csr_fire    = csr_valid;
      sts.req_valid   = req_tvalid;
      sts.is_clear    = (cmd_ff == CMD_CLEAR);
      sts.is_get      = (cmd_ff == CMD_GET);
      sts.oor         = (SW'(row_ff) >= dim) || (SW'(col_ff) >= dim);
      sts.ptr_eq_end  = (ptr_ff == end_ff);
      sts.row_hit     = (ent_rdata[EW-1:VAL_W] == row_ff);
      sts.full        = (count_ff == CNT_W'(MAX_ENTRIES));
      sts.shift_empty = (count_ff == end_ff);
      sts.cptr_eq_max = (cptr_ff == CA_W'(MAX_DIM));
      sts.rsp_free    = !rsp_valid_ff || rsp_tready;
   end
endmodule

// ===== design/sparse_column_matrix_store_unit.sv =====
// top level of the sparse column matrix store
// throughput: one command at a time, next beat taken the cycle after the result is loaded
// reset, size write and clear command run a clearing pass over all MAX_DIM+1 entries of the
//   column start ram, no command is taken meanwhile; size writes are always taken
module sparse_column_matrix_store_unit
   import scmsu_pkg::*;
#(
   parameter int MAX_DIM     = DEF_MAX_DIM,
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   // size register write, clears the store
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_wdata,
   // command beat
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // cmd[1:0], row[7:2], column[13:8], value[77:14], zero pad
   // result beat
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // entry_out[63:0], was_present[64], status[66:65], zero pad
);
   scmsu_ctl_type ctl;
   scmsu_sts_type sts;

   // sequencer: dispatch, clearing, column search, shift, start table update, result handoff
   scmsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .ctl       (ctl),
      .req_ready (req_tready)
   );

   // two rams, pointers and the output register
   scmsu_dp #(
      .MAX_DIM     (MAX_DIM),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ctl        (ctl),
      .sts        (sts)
   );
endmodule

// ===== tb/sparse_column_matrix_store_unit_tb.sv =====
// self-checking testbench for the sparse column matrix store against an in-bench model
module sparse_column_matrix_store_unit_tb;
   import scmsu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_LIMIT   = 64;
   localparam int ENTRY_LIMIT = 1024;

   typedef struct {
      logic [VAL_W-1:0] entry_out;
      logic             was_present;
      status_type       status;
   } matrix_result_type;

   // in-bench copy of the compressed column store and the queue of predicted results
   class matrix_scoreboard;
      int unsigned       dim_in_use;
      int unsigned       col_start [DIM_LIMIT+1];
      logic [5:0]        row_of [ENTRY_LIMIT];
      logic [VAL_W-1:0]  value_of [ENTRY_LIMIT];
      int unsigned       stored;
      matrix_result_type pending [$];
      int                errors;

      function void wipe();
         foreach (col_start[i]) col_start[i] = 0;
         stored = 0;
      endfunction

      function void set_size(logic [SIZE_W-1:0] sz);
         dim_in_use = (sz > DIM_LIMIT) ? DIM_LIMIT : sz;
         wipe();
      endfunction

      function logic [VAL_W-1:0] clamp_sum(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
         logic [VAL_W-1:0] s;
         s = a + b;
         if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
         return s;
      endfunction

      // work out the result of one accepted command and update the store
      function void note_command(cmd_type cmd, logic [5:0] r, logic [5:0] c,
                                 logic [VAL_W-1:0] v);
         matrix_result_type res;
         int unsigned       lo, hi, at;
         bit                hit;
         res.entry_out = '0;
         res.was_present = 1'b0;
         res.status = STATUS_OK;
         hit = 0;
         at = 0;
         if (cmd == CMD_CLEAR) begin
            wipe();
         end else if (r >= dim_in_use || c >= dim_in_use) begin
            res.status = STATUS_RANGE;
         end else begin
            lo = col_start[c];
            hi = col_start[c+1];
            if (hi > stored) hi = stored;
            for (int i = lo; i < hi; i++)
               if (!hit && row_of[i] == r) begin
                  hit = 1;
                  at = i;
               end
            if (cmd == CMD_GET) begin
               if (hit) begin
                  res.entry_out = value_of[at];
                  res.was_present = 1'b1;
               end
            end else if (!hit && stored >= ENTRY_LIMIT) begin
               res.status = STATUS_FULL;
            end else begin
               if (!hit) begin
                  // open a slot at the end of the column
                  for (int i = stored; i > hi; i--) begin
                     row_of[i] = row_of[i-1];
                     value_of[i] = value_of[i-1];
                  end
                  row_of[hi] = r;
                  value_of[hi] = '0;
                  stored++;
                  for (int i = c + 1; i <= DIM_LIMIT; i++) col_start[i]++;
                  at = hi;
               end
               value_of[at] = (cmd == CMD_SET) ? v : clamp_sum(value_of[at], v);
               res.entry_out = value_of[at];
               res.was_present = hit;
            end
         end
         pending.push_back(res);
      endfunction

      function void check_result(logic [RSP_W-1:0] beat);
         matrix_result_type want;
         if (pending.size() == 0) begin
            $error("result beat with no command outstanding: %h", beat);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (beat[63:0] !== want.entry_out) begin
            $error("entry_out expected %h actual %h", want.entry_out, beat[63:0]);
            errors++;
         end
         if (beat[64] !== want.was_present) begin
            $error("was_present expected %0d actual %0d", want.was_present, beat[64]);
            errors++;
         end
         if (beat[66:65] !== want.status) begin
            $error("status expected %0d actual %0d", want.status, beat[66:65]);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_wdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   matrix_scoreboard board = new();
   bit               long_hold = 0;   // receiver holds off while set
   bit               stall_free = 0;  // receiver takes every beat at once
   int               hold_cycles = 0;

   always #6 clock = ~clock;

   sparse_column_matrix_store_unit dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // result side: random stalls per beat, plus the long hold-off when asked
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = stall_free ? 0 : $urandom_range(0, 17);
         // ready only drops when there is an idle stretch to take
         if (long_hold || gap > 0) begin
            rsp_tready <= 1'b0;
            while (long_hold) @(posedge clock);
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_result(rsp_tdata);
      end
   end

   // long stall on the result side, counted in this process
   initial begin
      wait (hold_cycles > 0);
      long_hold = 1;
      repeat (hold_cycles) @(posedge clock);
      long_hold = 0;
   end

   task automatic size_write(logic [SIZE_W-1:0] sz);
      csr_valid <= 1'b1;
      csr_wdata <= sz;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.set_size(sz);
   endtask

   // offer one command beat; a random idle gap beforehand unless told not to
   task automatic send_command(cmd_type cmd, logic [5:0] r, logic [5:0] c,
                               logic [VAL_W-1:0] v, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, v, c, r, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_command(cmd, r, c, v);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 64'h7fff_ffff_ffff_ffff - $urandom_range(0, 3);
         1: return 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
         2: return {{32{1'b0}}, $urandom()};
         3: return -{{32{1'b0}}, $urandom()};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic cmd_type rand_cmd();
      int p;
      p = $urandom_range(0, 99);
      if (p < 30) return CMD_GET;
      if (p < 60) return CMD_SET;
      if (p < 99) return CMD_ADD;
      return CMD_CLEAR;
   endfunction

   // random phase: coordinates mostly inside the size, some outside
   task automatic random_phase(int count, int dim, bit no_gaps = 0);
      logic [5:0] r, c;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            r = 6'($urandom());
            c = 6'($urandom());
         end else begin
            r = (dim > 0) ? 6'($urandom_range(0, dim - 1)) : 6'($urandom());
            c = (dim > 0) ? 6'($urandom_range(0, dim - 1)) : 6'($urandom());
         end
         send_command(rand_cmd(), r, c, rand_value(), no_gaps || (n % 100 < 15));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // size zero: everything is out of range
      send_command(CMD_GET, 0, 0, 0);
      send_command(CMD_SET, 0, 0, 64'h1);
      drain();

      // directed: extremes, all commands, saturation both ways, present/absent
      size_write(7'd127);
      send_command(CMD_GET, 63, 63, 0);
      send_command(CMD_SET, 63, 63, 64'h7fff_ffff_ffff_ffff);
      send_command(CMD_ADD, 63, 63, 64'h1);
      send_command(CMD_SET, 0, 0, 64'h8000_0000_0000_0000);
      send_command(CMD_ADD, 0, 0, 64'hffff_ffff_ffff_ffff);
      send_command(CMD_ADD, 5, 0, 64'hffff_ffff_ffff_ffff);
      send_command(CMD_SET, 2, 0, 64'h0000_0001_8000_0000);
      send_command(CMD_GET, 5, 0, 0);
      send_command(CMD_GET, 63, 63, 0);
      send_command(CMD_GET, 1, 1, 0);
      send_command(CMD_SET, 17, 42, 64'haaaa_5555_aaaa_5555);
      send_command(CMD_ADD, 17, 42, 64'h5555_aaaa_5555_aaaa);
      send_command(CMD_CLEAR, 63, 63, '1);
      send_command(CMD_GET, 0, 0, 0);
      drain();

      size_write(7'd64);
      send_command(CMD_SET, 1, 1, 64'h1);
      drain();
      size_write(7'd1);
      send_command(CMD_GET, 1, 1, 0);
      send_command(CMD_SET, 0, 0, 64'h12);
      send_command(CMD_GET, 0, 0, 0);
      send_command(CMD_GET, 0, 1, 0);
      drain();

      // long receiver stall while commands keep coming
      size_write(7'd8);
      hold_cycles = 3000;
      random_phase(60, 8, 1);
      drain();

      // fill the store completely to reach the full status
      size_write(7'd64);
      stall_free = 1;
      for (int k = 0; k < ENTRY_LIMIT; k++)
         send_command(CMD_SET, 6'(k % 64), 6'(63 - k / 64), {32'h0, k}, 1);
      send_command(CMD_SET, 0, 0, 64'h5, 1);
      send_command(CMD_ADD, 5, 50, 64'h5, 1);
      send_command(CMD_GET, 63, 48, 0, 1);
      send_command(CMD_CLEAR, 0, 0, 0, 1);
      send_command(CMD_SET, 0, 0, 64'h5, 1);
      drain();
      stall_free = 0;

      // random phases over several sizes
      size_write(7'd4);
      random_phase(200, 4);
      drain();
      size_write(7'd64);
      random_phase(150, 64);
      drain();
      size_write(7'd12);
      random_phase(250, 12);
      drain();
      size_write(7'd100);
      random_phase(100, 64);
      drain();
      size_write(7'd2);
      random_phase(60, 2);
      drain();

      if (board.errors == 0)
         $display("sparse_column_matrix_store_unit_tb OK");
      else
         $display("sparse_column_matrix_store_unit_tb NOT OK");
      $finish;
   end

   initial begin
      #150ms;
      $display("sparse_column_matrix_store_unit_tb NOT OK");
      $finish;
   end
endmodule
